### hw/rtl/sapf_pkg.sv
`default_nettype none
package sapf_pkg;
	localparam int unsigned CoordW = 32;
	localparam int unsigned IdW = 16;
	localparam int unsigned PosW = 5;
	localparam int unsigned ResultCap = 31;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_INSERT = 2'd1,
		OP_SWEEP = 2'd2,
		OP_RSVD = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_OK = 2'd0,
		ERR_FULL = 2'd1,
		ERR_POS = 2'd2
	} err_t;

	// one stored body
	typedef struct packed {
		logic [CoordW-1:0] left;
		logic [CoordW-1:0] right;
		logic [CoordW-1:0] bottom;
		logic [CoordW-1:0] top;
		logic [IdW-1:0] ident;
		logic moving;
		logic asleep;
	} entry_t;

	localparam int unsigned EntryW = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic clear;
		logic rd_en;
		logic rd_from_cursor;
		logic wr_shift;
		logic wr_new;
		logic cursor_dec;
		logic cursor_inc;
		logic count_inc;
		logic cap_swept;
		logic hold_pair;
		logic emit_pair;
		logic emit_last;
		logic emit_done;
		err_t emit_err;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic pos_bad;
		logic cursor_zero;
		logic cursor_at_end;
		logic prev_greater;
		logic past_right;
		logic pair_ok;
		logic cap_hit;
		logic held;
	} dp_stat_t;
endpackage
`default_nettype wire

### hw/rtl/sweep_and_prune_pair_finder.sv
`default_nettype none
// channel | handshake            | fields
// input   | in_valid, in_stall   | opcode, body_id, box edges, flags, sweep_position
// output  | out_valid, out_stall | pair_found, first_id, second_id, last_result, status
// clear, reserved and rejected insert: result in the cycle after the transfer
// insert: read the entry below the cursor, shift each entry with a larger left edge up,
// then write the new body and answer; sweep: read each later entry, then compare it;
// a bad position answers ERR_POS; a pair goes out once the next pair or the end is known
// arst_n clears the count and control; table entries are used only after they are written
// a waiting result holds the controller at its next send; in_stall is high while busy or while a result waits
module sweep_and_prune_pair_finder #(
	parameter int unsigned MaxBodies = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] opcode,
	input wire logic [15:0] body_id,
	input wire logic signed [31:0] box_min_x,
	input wire logic signed [31:0] box_max_x,
	input wire logic signed [31:0] box_min_y,
	input wire logic signed [31:0] box_max_y,
	input wire logic is_dynamic,
	input wire logic is_sleeping,
	input wire logic [4:0] sweep_position,
	output logic out_valid,
	input wire logic out_stall,
	output logic pair_found,
	output logic [15:0] first_id,
	output logic [15:0] second_id,
	output logic last_result,
	output logic [1:0] error_code,
	output logic [5:0] stored_count
);
	import sapf_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	sapf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .stat(stat)
	);

	sapf_datapath #(.MaxBodies(MaxBodies)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.body_id(body_id), .box_min_x(box_min_x), .box_max_x(box_max_x),
		.box_min_y(box_min_y), .box_max_y(box_max_y),
		.is_dynamic(is_dynamic), .is_sleeping(is_sleeping),
		.sweep_position(sweep_position),
		.pair_found(pair_found), .first_id(first_id), .second_id(second_id),
		.last_result(last_result), .error_code(error_code), .stored_count(stored_count)
	);

	// checks
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != ERR_OK) |-> last_result && !pair_found)
		else $error("error result not final");
	a_pair_not_last_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pair_found |-> error_code == ERR_OK)
		else $error("pair with error");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({pair_found, first_id, second_id,
			last_result, error_code, stored_count}))
		else $error("stalled result changed");
endmodule
`default_nettype wire

### hw/rtl/sapf_ram.sv
`default_nettype none
module sapf_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/sapf_datapath.sv
`default_nettype none
module sapf_datapath #(
	parameter int unsigned MaxBodies = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire sapf_pkg::dp_cmd_t cmd,
	output sapf_pkg::dp_stat_t stat,
	input wire logic [15:0] body_id,
	input wire logic signed [31:0] box_min_x,
	input wire logic signed [31:0] box_max_x,
	input wire logic signed [31:0] box_min_y,
	input wire logic signed [31:0] box_max_y,
	input wire logic is_dynamic,
	input wire logic is_sleeping,
	input wire logic [4:0] sweep_position,
	output logic pair_found,
	output logic [15:0] first_id,
	output logic [15:0] second_id,
	output logic last_result,
	output logic [1:0] error_code,
	output logic [5:0] stored_count
);
	import sapf_pkg::*;

	localparam int unsigned AddrW = $clog2(MaxBodies);
	localparam int unsigned CntW = $clog2(MaxBodies + 1);
	localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
	localparam int unsigned NpW = $clog2(ResultCap + 1);

	entry_t new_q;
	entry_t swept_q;
	entry_t rd_data;
	entry_t wr_data;
	logic [AddrW-1:0] waddr;
	logic [AddrW-1:0] raddr;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] cursor_q;
	logic [CntW-1:0] count_next;
	logic [PosW-1:0] pos_q;
	logic [NpW-1:0] npairs_q;
	logic held_q;
	logic [IdW-1:0] held_id_q;

	// item registers and the pair waiting for its last flag
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			new_q.left <= box_min_x;
			new_q.right <= box_max_x;
			new_q.bottom <= box_min_y;
			new_q.top <= box_max_y;
			new_q.ident <= body_id;
			new_q.moving <= is_dynamic;
			new_q.asleep <= is_sleeping;
			pos_q <= sweep_position;
		end
		if (cmd.cap_swept) begin
			swept_q <= rd_data;
		end
		if (cmd.hold_pair) begin
			held_id_q <= rd_data.ident;
		end
	end

	// count, cursor and pair counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cursor_q <= '0;
			npairs_q <= '0;
			held_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.load_item) begin
				cursor_q <= count_q;
			end else if (cmd.cap_swept) begin
				cursor_q <= CntW'(pos_q) + 1'b1;
			end else if (cmd.cursor_dec) begin
				cursor_q <= cursor_q - 1'b1;
			end else if (cmd.cursor_inc) begin
				cursor_q <= cursor_q + 1'b1;
			end
			if (cmd.load_item) begin
				npairs_q <= '0;
				held_q <= 1'b0;
			end else if (cmd.hold_pair) begin
				npairs_q <= npairs_q + 1'b1;
				held_q <= 1'b1;
			end
		end
	end

	// read address: sweep position, cursor, or the entry below the next write
	always_comb begin
		if (cmd.load_item) begin
			raddr = AddrW'(sweep_position);
		end else if (cmd.rd_from_cursor) begin
			raddr = cursor_q[AddrW-1:0];
		end else if (cmd.cursor_dec) begin
			raddr = AddrW'(cursor_q - 2'd2);
		end else begin
			raddr = AddrW'(cursor_q - 1'b1);
		end
	end

	assign wr_data = cmd.wr_new ? new_q : rd_data;
	assign waddr = cursor_q[AddrW-1:0];

	sapf_ram #(.Width(EntryW), .Depth(MaxBodies)) u_table (
		.clk(clk),
		.we(cmd.wr_shift | cmd.wr_new),
		.waddr(waddr),
		.wdata(wr_data),
		.re(cmd.rd_en | cmd.load_item),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// compares
	always_comb begin
		stat.full = (count_q >= CntW'(MaxBodies));
		stat.pos_bad = (CmpW'(pos_q) >= CmpW'(count_q));
		stat.cursor_zero = (cursor_q == '0);
		stat.cursor_at_end = (cursor_q >= count_q);
		stat.prev_greater = ($signed(rd_data.left) > $signed(new_q.left));
		stat.past_right = ($signed(rd_data.left) > $signed(swept_q.right));
		stat.pair_ok = (swept_q.moving | rd_data.moving)
			&& !(swept_q.asleep & rd_data.asleep)
			&& ($signed(swept_q.left) <= $signed(rd_data.right))
			&& ($signed(rd_data.left) <= $signed(swept_q.right))
			&& ($signed(swept_q.bottom) <= $signed(rd_data.top))
			&& ($signed(rd_data.bottom) <= $signed(swept_q.top));
		stat.cap_hit = (npairs_q == NpW'(ResultCap));
		stat.held = held_q;
	end

	assign count_next = cmd.clear ? '0 : count_q + CntW'(cmd.count_inc);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit_pair) begin
			pair_found <= 1'b1;
			first_id <= swept_q.ident;
			second_id <= held_id_q;
			last_result <= cmd.emit_last;
			error_code <= ERR_OK;
			stored_count <= 6'(count_q);
		end else if (cmd.emit_done) begin
			pair_found <= 1'b0;
			first_id <= '0;
			second_id <= '0;
			last_result <= 1'b1;
			error_code <= cmd.emit_err;
			stored_count <= 6'(count_next);
		end
	end
endmodule
`default_nettype wire

### hw/rtl/sapf_ctrl.sv
`default_nettype none
module sapf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] opcode,
	output logic out_valid,
	input wire logic out_stall,
	output sapf_pkg::dp_cmd_t cmd,
	input wire sapf_pkg::dp_stat_t stat
);
	import sapf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_SW_LOAD,
		S_SW_RD,
		S_SW_CHK
	} state_t;

	state_t state_q;
	logic out_free;
	logic sweep_stop;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign sweep_stop = stat.cursor_at_end || stat.past_right || stat.cap_hit;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			out_valid <= cmd.emit_pair || cmd.emit_done || (out_valid && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						case (opcode_t'(opcode))
							OP_INSERT: state_q <= stat.full ? S_IDLE : S_INS_RD;
							OP_SWEEP: state_q <= S_SW_LOAD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_INS_RD: state_q <= S_INS_CHK;
				S_INS_CHK: begin
					if (cmd.emit_done) state_q <= S_IDLE;
				end
				S_SW_LOAD: begin
					if (!stat.pos_bad) begin
						state_q <= S_SW_RD;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SW_RD: state_q <= S_SW_CHK;
				S_SW_CHK: begin
					if (out_free) state_q <= sweep_stop ? S_IDLE : S_SW_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		cmd.emit_err = ERR_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.load_item = 1'b1;
					case (opcode_t'(opcode))
						OP_CLEAR: begin
							cmd.clear = 1'b1;
							cmd.emit_done = 1'b1;
						end
						OP_INSERT: begin
							if (stat.full) begin
								cmd.emit_done = 1'b1;
								cmd.emit_err = ERR_FULL;
							end
						end
						OP_SWEEP: ;
						default: cmd.emit_done = 1'b1;
					endcase
				end
			end
			S_INS_RD: begin
				// read the entry below the cursor if there is one
				cmd.rd_en = !stat.cursor_zero;
			end
			S_INS_CHK: begin
				if (!stat.cursor_zero && stat.prev_greater) begin
					cmd.wr_shift = 1'b1;
					cmd.cursor_dec = 1'b1;
					cmd.rd_en = 1'b1;
				end else if (out_free) begin
					cmd.wr_new = 1'b1;
					cmd.count_inc = 1'b1;
					cmd.emit_done = 1'b1;
				end
			end
			S_SW_LOAD: begin
				if (stat.pos_bad) begin
					if (out_free) begin
						cmd.emit_done = 1'b1;
						cmd.emit_err = ERR_POS;
					end
				end else begin
					cmd.cap_swept = 1'b1;
				end
			end
			S_SW_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_from_cursor = 1'b1;
			end
			S_SW_CHK: begin
				if (out_free) begin
					if (sweep_stop) begin
						// flush the held pair as the last one, or report no pair
						if (stat.held) begin
							cmd.emit_pair = 1'b1;
							cmd.emit_last = 1'b1;
						end else begin
							cmd.emit_done = 1'b1;
						end
					end else begin
						cmd.cursor_inc = 1'b1;
						if (stat.pair_ok) begin
							cmd.hold_pair = 1'b1;
							cmd.emit_pair = stat.held;
						end
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

// table of bodies kept sorted by left edge, with the pairs each request yields
class pair_board;
	logic signed [31:0] lft[32], rgt[32], bot[32], tp[32];
	logic [15:0] ids[32];
	logic mov[32], slp[32];
	int unsigned cnt;
	logic [41:0] pending[$];
	int mismatches;
	int pairs_seen;

	function new();
		cnt = 0;
		mismatches = 0;
		pairs_seen = 0;
	endfunction

	function void push(logic pf, logic [15:0] a, logic [15:0] b, logic lr, logic [1:0] e);
		pending.insert(pending.size(), {pf, a, b, lr, e, cnt[5:0]});
	endfunction

	// note one accepted input transfer
	function void note_request(logic [1:0] op, logic [15:0] id, logic signed [31:0] x0,
			logic signed [31:0] x1, logic signed [31:0] y0, logic signed [31:0] y1,
			logic dyn, logic sl, logic [4:0] pos);
		int j, n, first;
		n = 0;
		first = pending.size();
		case (op)
			sapf_pkg::OP_CLEAR: begin
				cnt = 0;
				push(1'b0, '0, '0, 1'b1, sapf_pkg::ERR_OK);
			end
			sapf_pkg::OP_INSERT: begin
				if (cnt >= 32) begin
					push(1'b0, '0, '0, 1'b1, sapf_pkg::ERR_FULL);
				end else begin
					j = cnt;
					while (j > 0 && lft[j-1] > x0) begin
						lft[j] = lft[j-1]; rgt[j] = rgt[j-1];
						bot[j] = bot[j-1]; tp[j] = tp[j-1];
						ids[j] = ids[j-1]; mov[j] = mov[j-1]; slp[j] = slp[j-1];
						j--;
					end
					lft[j] = x0; rgt[j] = x1; bot[j] = y0; tp[j] = y1;
					ids[j] = id; mov[j] = dyn; slp[j] = sl;
					cnt++;
					push(1'b0, '0, '0, 1'b1, sapf_pkg::ERR_OK);
				end
			end
			sapf_pkg::OP_SWEEP: begin
				if (pos >= cnt) begin
					push(1'b0, '0, '0, 1'b1, sapf_pkg::ERR_POS);
				end else begin
					for (j = pos + 1; j < cnt && n < 31; j++) begin
						if (lft[j] > rgt[pos]) break;
						if (!mov[pos] && !mov[j]) continue;
						if (slp[pos] && slp[j]) continue;
						if (!(lft[pos] <= rgt[j] && lft[j] <= rgt[pos] &&
								bot[pos] <= tp[j] && bot[j] <= tp[pos])) continue;
						push(1'b1, ids[pos], ids[j], 1'b0, sapf_pkg::ERR_OK);
						n++;
					end
					if (n == 0) push(1'b0, '0, '0, 1'b1, sapf_pkg::ERR_OK);
					else pending[first + n - 1][8] = 1'b1;
					pairs_seen += n;
				end
			end
			default: push(1'b0, '0, '0, 1'b1, sapf_pkg::ERR_OK);
		endcase
	endfunction

	// compare one output transfer with the oldest expectation
	function void check_result(logic [41:0] got);
		logic [41:0] want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: expected pf=%b a=%h b=%h last=%b err=%0d cnt=%0d",
					want[41], want[40:25], want[24:9], want[8], want[7:6], want[5:0]);
				$display("          actual   pf=%b a=%h b=%h last=%b err=%0d cnt=%0d",
					got[41], got[40:25], got[24:9], got[8], got[7:6], got[5:0]);
			end
		end
	endfunction
endclass

module testbench;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] opcode = 0;
	logic [15:0] body_id = 0;
	logic signed [31:0] box_min_x = 0, box_max_x = 0, box_min_y = 0, box_max_y = 0;
	logic is_dynamic = 0, is_sleeping = 0;
	logic [4:0] sweep_position = 0;
	logic out_valid;
	logic out_stall = 1;
	logic pair_found, last_result;
	logic [15:0] first_id, second_id;
	logic [1:0] error_code;
	logic [5:0] stored_count;

	pair_board board = new();
	int idle_cycles = 0;
	int results_seen = 0;
	int items_sent = 0;
	bit hold_off = 0;

	sweep_and_prune_pair_finder dut (.*);

	always #2 clk = ~clk;

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				board.note_request(opcode, body_id, box_min_x, box_max_x, box_min_y,
					box_max_y, is_dynamic, is_sleeping, sweep_position);
				items_sent++;
			end
			if (out_valid && !out_stall) begin
				board.check_result({pair_found, first_id, second_id, last_result,
					error_code, stored_count});
				results_seen++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > 2000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver: random wait per result, with one long hold-off on request
	initial begin
		int k;
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				for (k = 0; k < 300; k++) @(negedge clk);
				hold_off = 0;
			end
			w = $urandom_range(0, 4);
			if (w != 0) begin
				out_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// present one request and wait for its transfer
	task automatic send(logic [1:0] op, logic [15:0] id, logic signed [31:0] x0,
			logic signed [31:0] x1, logic signed [31:0] y0, logic signed [31:0] y1,
			logic dyn, logic sl, logic [4:0] pos);
		int g;
		g = $urandom_range(0, 4);
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		opcode <= op; body_id <= id;
		box_min_x <= x0; box_max_x <= x1; box_min_y <= y0; box_max_y <= y1;
		is_dynamic <= dyn; is_sleeping <= sl; sweep_position <= pos;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_simple(logic [1:0] op, logic [4:0] pos);
		send(op, '0, '0, '0, '0, '0, 1'b0, 1'b0, pos);
	endtask

	task automatic random_insert(int spread);
		logic signed [31:0] x0, y0;
		x0 = $signed($urandom_range(0, spread)) - spread / 2;
		y0 = $signed($urandom_range(0, spread)) - spread / 2;
		send(sapf_pkg::OP_INSERT, 16'($urandom), x0, x0 + $urandom_range(0, spread / 3),
			y0, y0 + $urandom_range(0, spread / 3), 1'($urandom), 1'($urandom), 5'd0);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		int i, k, spread;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, every opcode, empty sweeps, inverted box, full table
		send_simple(sapf_pkg::OP_SWEEP, 5'd0);
		send(sapf_pkg::OP_RSVD, 16'hffff, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
			1'b1, 1'b1, 5'h1f);
		send(sapf_pkg::OP_INSERT, 16'hffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 1'b1, 1'b0, 5'd0);
		send(sapf_pkg::OP_INSERT, 16'h0000, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 1'b0, 1'b1, 5'd0);
		send(sapf_pkg::OP_INSERT, 16'h1234, 32'sh80000000, 32'sh80000000,
			32'sd0, 32'sd0, 1'b0, 1'b0, 5'd0);
		send(sapf_pkg::OP_INSERT, 16'h0055, 32'sd100, -32'sd100, 32'sd0, 32'sd10,
			1'b1, 1'b1, 5'd0);
		send_simple(sapf_pkg::OP_SWEEP, 5'd0);
		send_simple(sapf_pkg::OP_SWEEP, 5'd1);
		send_simple(sapf_pkg::OP_SWEEP, 5'd3);
		send_simple(sapf_pkg::OP_SWEEP, 5'd4);
		send_simple(sapf_pkg::OP_SWEEP, 5'h1f);
		send_simple(sapf_pkg::OP_CLEAR, 5'd0);
		// fill with equal keys then overflow
		for (i = 0; i < 33; i++)
			send(sapf_pkg::OP_INSERT, 16'(i), 32'sd0, 32'sd5, 32'sd0, 32'sd5,
				i[0], i[1], 5'd0);
		send_simple(sapf_pkg::OP_SWEEP, 5'd0);
		send_simple(sapf_pkg::OP_SWEEP, 5'h1f);

		// long receiver hold-off while requests keep coming
		hold_off = 1;
		for (i = 0; i < 12; i++)
			send_simple(sapf_pkg::OP_SWEEP, 5'($urandom_range(0, 31)));

		// random: fill sessions with clustered boxes, then sweep them
		while (items_sent < 200) begin
			send_simple(sapf_pkg::OP_CLEAR, 5'd0);
			k = $urandom_range(1, 34);
			spread = ($urandom_range(0, 3) == 0) ? 32'h7fffffff
				: int'($urandom_range(40, 4000));
			for (i = 0; i < k; i++) random_insert(spread);
			for (i = 0; i < 8; i++)
				send(($urandom_range(0, 9) == 0) ? sapf_pkg::OP_RSVD : sapf_pkg::OP_SWEEP,
					16'($urandom), $urandom, $urandom, $urandom, $urandom,
					1'($urandom), 1'($urandom), 5'($urandom_range(0, 31)));
		end
		in_valid <= 1'b0;
		drain();

		$display("covered %0d requests, %0d results, %0d reported pairs",
			items_sent, results_seen, board.pairs_seen);
		$display("with a full table, rejected inserts, bad positions and a long output hold");
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
